>>> hdl/lzc_pkg.sv
// Shared constants and types of the LZ77 byte compressor.
package lzc_pkg;

  localparam int unsigned LZC_WINDOW    = 255;
  localparam int unsigned LZC_MAX_MATCH = 255;
  localparam int unsigned LZC_GRP_SIZE  = 16;

  typedef struct packed {
    logic step;
    logic clear;
    logic open;
    logic limit;
  } lzc_cell_ctrl_t;

  typedef struct packed {
    logic [7:0] distance;
    logic [7:0] match_len;
    logic [7:0] next_char;
    logic       has_next_char;
    logic       final_token;
  } lzc_token_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GRP  = 3'b010,
    S_DEC  = 3'b100
  } lzc_state_e;

endpackage

>>> hdl/lzc_intf.sv
// Valid/ready channel interfaces for input bytes and output tokens.
interface lzc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] distance;
  logic [7:0] match_len;
  logic [7:0] next_char;
  logic       has_next_char;
  logic       final_token;

  modport source (output valid, output distance, output match_len, output next_char,
                  output has_next_char, output final_token, input ready);
  modport sink (input valid, input distance, input match_len, input next_char,
                input has_next_char, input final_token, output ready);
endinterface

>>> hdl/lzc_cell.sv
// One window cell: a history byte at a fixed back distance and its match flag.
module lzc_cell #(
  parameter int unsigned IDX = 1,
  parameter int unsigned BSW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lzc_pkg::lzc_cell_ctrl_t ctrl_i,
  input  logic [BSW-1:0]          bytes_seen_i,
  input  logic [7:0]              data_i,
  input  logic [7:0]              hist_i,
  output logic [7:0]              hist_o,
  output logic                    alive_o
);
  import lzc_pkg::*;

  localparam logic [BSW-1:0] IdxV = BSW'(IDX);

  logic [7:0] hist_q;
  logic       alive_q, alive_d;
  logic       hit;

  assign hit = (hist_q == data_i);

  always_comb begin
    alive_d = alive_q;
    if (ctrl_i.clear) begin
      alive_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.limit) begin
        alive_d = 1'b0;
      end else if (!ctrl_i.open) begin
        alive_d = (IdxV <= bytes_seen_i) && hit;
      end else begin
        alive_d = alive_q && hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      hist_q <= hist_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  assign hist_o  = hist_q;
  assign alive_o = alive_q;
endmodule

>>> hdl/lzc_prio.sv
// Registered priority encoder over one group of cells, nearest distance first.
module lzc_prio #(
  parameter int unsigned GW = 16
) (
  input  logic                  clk_i,
  input  logic [GW-1:0]         alive_i,
  output logic                  any_o,
  output logic [$clog2(GW)-1:0] first_o
);
  import lzc_pkg::*;

  localparam int unsigned LW = $clog2(GW);

  logic          any_q;
  logic [LW-1:0] first_q, first_d;

  always_comb begin
    first_d = '0;
    for (int i = GW - 1; i >= 0; i--) begin
      if (alive_i[i]) begin
        first_d = LW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    any_q   <= |alive_i;
    first_q <= first_d;
  end

  assign any_o   = any_q;
  assign first_o = first_q;
endmodule

>>> hdl/lz77_byte_compressor.sv
// Top level of the greedy LZ77 byte compressor with a row of window cells.
//
// Bytes enter on in_i, one word per accepted valid/ready handshake, with
// last_byte marking the end of a stream. Tokens leave on out_o as
// (distance, match_len, next_char, has_next_char, final_token) words.
// A literal is (0, 0, byte); a stream that ends inside a match closes with
// has_next_char low.
// For each byte, the accept edge updates every cell's match flag in parallel,
// the group priority encoders then register their results, and the decision
// state picks the nearest live distance and decides on a token. A token
// appears on out_o on the cycle after that decision. in_i is ready only in
// the idle state, so a new byte is taken only once the last one is decided.
// The output word sits in a register, so a new byte is taken while a token
// still waits; only a decision that must emit waits for the register to drain.
// Reset clears the match flags, the open match and the fill count at once;
// the history bytes need no clearing since only filled distances are used.
// After the last byte of a stream the block starts a fresh window.
module lz77_byte_compressor #(
  parameter int unsigned WINDOW_SIZE = lzc_pkg::LZC_WINDOW,
  parameter int unsigned MAX_MATCH   = lzc_pkg::LZC_MAX_MATCH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzc_in_if.sink    in_i,
  lzc_out_if.source out_o
);
  import lzc_pkg::*;

  localparam int unsigned GW   = LZC_GRP_SIZE;
  localparam int unsigned LW   = $clog2(GW);
  localparam int unsigned NGRP = (WINDOW_SIZE + GW - 1) / GW;
  localparam int unsigned GIW  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned BSW  = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned DW   = GIW + LW + 1;

  lzc_state_e state_q, state_d;
  logic [7:0]     data_q, data_d;
  logic           last_q, last_d;
  logic           open_q, open_d;
  logic [7:0]     len_q, len_d;
  logic [7:0]     bestd_q, bestd_d;
  logic [BSW-1:0] bs_q, bs_d;
  logic           oval_q, oval_d;
  lzc_token_t     tok_q, tok_d;

  logic           in_fire, take_out, clear;
  lzc_cell_ctrl_t cctl;
  logic [7:0]     hist_w [0:WINDOW_SIZE];
  logic [NGRP*GW-1:0] alive_w;
  logic [NGRP-1:0]    g_any;
  logic [LW-1:0]      g_first [0:NGRP-1];

  logic [GIW-1:0] sel_g;
  logic           any_all;
  logic [DW-1:0]  best_dist;
  logic [7:0]     best8;

  logic       dec_emit, dec_close, dec_open;
  logic [7:0] dec_len, dec_best;
  lzc_token_t dec_tok;
  logic       stall;

  assign in_fire  = in_i.valid && in_i.ready;
  assign take_out = oval_q && out_o.ready;

  assign cctl.step  = in_fire;
  assign cctl.clear = clear;
  assign cctl.open  = open_q;
  assign cctl.limit = open_q && (len_q >= 8'(MAX_MATCH));

  assign hist_w[0] = in_i.data_byte;

  for (genvar k = 1; k <= WINDOW_SIZE; k++) begin : g_cell
    lzc_cell #(
      .IDX (k),
      .BSW (BSW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cctl),
      .bytes_seen_i (bs_q),
      .data_i       (in_i.data_byte),
      .hist_i       (hist_w[k-1]),
      .hist_o       (hist_w[k]),
      .alive_o      (alive_w[k-1])
    );
  end

  if (NGRP * GW > WINDOW_SIZE) begin : g_pad
    assign alive_w[NGRP*GW-1:WINDOW_SIZE] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    lzc_prio #(
      .GW (GW)
    ) u_prio (
      .clk_i   (clk_i),
      .alive_i (alive_w[g*GW +: GW]),
      .any_o   (g_any[g]),
      .first_o (g_first[g])
    );
  end

  always_comb begin
    sel_g = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        sel_g = GIW'(g);
      end
    end
  end

  assign any_all   = |g_any;
  assign best_dist = DW'({sel_g, g_first[sel_g]}) + DW'(1);
  assign best8     = 8'(best_dist);

  always_comb begin
    dec_emit  = 1'b0;
    dec_close = last_q;
    dec_open  = open_q;
    dec_len   = len_q;
    dec_best  = bestd_q;
    dec_tok   = '{distance: bestd_q, match_len: len_q, next_char: data_q,
                  has_next_char: 1'b1, final_token: last_q};
    if (!open_q) begin
      if (!any_all) begin
        dec_emit  = 1'b1;
        dec_close = 1'b1;
        dec_tok   = '{distance: 8'd0, match_len: 8'd0, next_char: data_q,
                      has_next_char: 1'b1, final_token: last_q};
      end else if (last_q) begin
        dec_emit  = 1'b1;
        dec_close = 1'b1;
        dec_tok   = '{distance: best8, match_len: 8'd1, next_char: 8'd0,
                      has_next_char: 1'b0, final_token: 1'b1};
      end else begin
        dec_open = 1'b1;
        dec_len  = 8'd1;
        dec_best = best8;
      end
    end else if (len_q >= 8'(MAX_MATCH) || !any_all) begin
      dec_emit  = 1'b1;
      dec_close = 1'b1;
    end else begin
      dec_len  = len_q + 8'd1;
      dec_best = best8;
      if (last_q) begin
        dec_emit  = 1'b1;
        dec_close = 1'b1;
        dec_tok   = '{distance: best8, match_len: len_q + 8'd1, next_char: 8'd0,
                      has_next_char: 1'b0, final_token: 1'b1};
      end
    end
  end

  assign stall = dec_emit && oval_q && !out_o.ready;

  always_comb begin
    state_d = state_q;
    data_d  = data_q;
    last_d  = last_q;
    open_d  = open_q;
    len_d   = len_q;
    bestd_d = bestd_q;
    bs_d    = bs_q;
    clear   = 1'b0;
    oval_d  = take_out ? 1'b0 : oval_q;
    tok_d   = tok_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          data_d  = in_i.data_byte;
          last_d  = in_i.last_byte;
          state_d = S_GRP;
          if (bs_q < BSW'(WINDOW_SIZE)) begin
            bs_d = bs_q + BSW'(1);
          end
        end
      end
      S_GRP: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        if (!stall) begin
          state_d = S_IDLE;
          if (dec_emit) begin
            oval_d = 1'b1;
            tok_d  = dec_tok;
          end
          if (dec_close) begin
            clear   = 1'b1;
            open_d  = 1'b0;
            len_d   = 8'd0;
            bestd_d = 8'd0;
          end else begin
            open_d  = dec_open;
            len_d   = dec_len;
            bestd_d = dec_best;
          end
          if (last_q) begin
            bs_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      open_q  <= 1'b0;
      len_q   <= 8'd0;
      bestd_q <= 8'd0;
      bs_q    <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      len_q   <= len_d;
      bestd_q <= bestd_d;
      bs_q    <= bs_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    tok_q  <= tok_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = oval_q;
  assign out_o.distance      = tok_q.distance;
  assign out_o.match_len     = tok_q.match_len;
  assign out_o.next_char     = tok_q.next_char;
  assign out_o.has_next_char = tok_q.has_next_char;
  assign out_o.final_token   = tok_q.final_token;

  a_rise_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) |-> $past(state_q == S_DEC))
    else $error("Token appeared without a decision cycle.");

  a_idle_no_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !open_q) |-> (alive_w == '0))
    else $error("Match flags left set with no open match.");

  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (len_q != 8'd0 && len_q <= 8'(MAX_MATCH)))
    else $error("Open match length out of range.");
endmodule

>>> test/tb_top.sv
// Self-checking testbench for the LZ77 byte compressor with randomized valid/ready traffic.
`timescale 1ns / 1ps

module tb_top;
  import lzc_pkg::*;

  localparam int unsigned HIST_DEPTH     = LZC_WINDOW + 1;
  localparam int unsigned QUIET_LIMIT    = 5000;
  localparam int unsigned HOLD_AT_BYTE   = 700;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned RANDOM_ITEMS   = 1600;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          drain;
    int unsigned gap_after;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_data  = 8'd0;
  logic       drv_last  = 1'b0;
  logic       rcv_ready = 1'b0;

  lzc_in_if  in_if ();
  lzc_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.data_byte = drv_data;
  assign in_if.last_byte = drv_last;
  assign out_if.ready    = rcv_ready;

  lz77_byte_compressor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stim_t       byte_q[$];
  lzc_token_t  token_q[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_taken    = 0;
  int unsigned tokens_seen    = 0;
  int unsigned gap_left       = 0;
  int unsigned rcv_stall      = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  logic [7:0]  window_mem[HIST_DEPTH];
  bit          alive[1:LZC_WINDOW];
  int unsigned wr_pos     = 0;
  int unsigned fill_cnt   = 0;
  int unsigned open_len   = 0;
  int unsigned best_dist  = 0;
  bit          match_open = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned pct;
    pct = $urandom_range(0, 99);
    if (pct < 55) return 0;
    if (pct < 85) return $urandom_range(1, 3);
    if (pct < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_match();
    match_open = 1'b0;
    open_len   = 0;
    best_dist  = 0;
    for (int d = 1; d <= LZC_WINDOW; d++) alive[d] = 1'b0;
  endfunction

  function automatic logic [7:0] byte_back(input int unsigned d);
    return window_mem[(wr_pos + HIST_DEPTH - d) % HIST_DEPTH];
  endfunction

  // Greedy match tracking for one accepted byte; a token, if any, goes to token_q.
  function automatic void lz77_predict(input logic [7:0] b, input logic last);
    lzc_token_t  tok;
    int unsigned best;
    bit          fire;
    fire = 1'b0;
    best = 0;
    tok.distance      = 8'd0;
    tok.match_len     = 8'd0;
    tok.next_char     = b;
    tok.has_next_char = 1'b1;
    tok.final_token   = last;
    if (!match_open) begin
      for (int d = 1; d <= LZC_WINDOW; d++) begin
        if (d <= fill_cnt) begin
          alive[d] = (byte_back(d) == b);
          if (alive[d] && best == 0) best = d;
        end
      end
      if (best == 0) begin
        fire = 1'b1;
      end else if (last) begin
        fire              = 1'b1;
        tok.distance      = 8'(best);
        tok.match_len     = 8'd1;
        tok.next_char     = 8'd0;
        tok.has_next_char = 1'b0;
      end else begin
        match_open = 1'b1;
        open_len   = 1;
        best_dist  = best;
      end
    end else if (open_len >= LZC_MAX_MATCH) begin
      fire          = 1'b1;
      tok.distance  = 8'(best_dist);
      tok.match_len = 8'(open_len);
    end else begin
      for (int d = 1; d <= LZC_WINDOW; d++) begin
        if (alive[d]) begin
          alive[d] = (byte_back(d) == b);
          if (alive[d] && best == 0) best = d;
        end
      end
      if (best == 0) begin
        fire          = 1'b1;
        tok.distance  = 8'(best_dist);
        tok.match_len = 8'(open_len);
      end else begin
        open_len++;
        best_dist = best;
        if (last) begin
          fire              = 1'b1;
          tok.distance      = 8'(best_dist);
          tok.match_len     = 8'(open_len);
          tok.next_char     = 8'd0;
          tok.has_next_char = 1'b0;
        end
      end
    end
    if (fire) begin
      token_q = {token_q, tok};
      clear_match();
    end
    window_mem[wr_pos] = b;
    wr_pos = (wr_pos + 1) % HIST_DEPTH;
    if (fill_cnt < LZC_WINDOW) fill_cnt++;
    if (last) begin
      fill_cnt = 0;
      clear_match();
    end
  endfunction

  function automatic void queue_stream(input byte_seq_t s, input bit calm, input bit drain);
    stim_t w;
    foreach (s[i]) begin
      w.data      = s[i];
      w.last      = (i == s.size() - 1);
      w.drain     = drain && (i == 0);
      w.gap_after = calm ? 0 : pick_gap();
      byte_q = {byte_q, w};
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_data  <= 8'd0;
      drv_last  <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (drv_valid && in_if.ready) begin
        lz77_predict(drv_data, drv_last);
        bytes_taken <= bytes_taken + 1;
      end
      if (!drv_valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          drv_valid <= 1'b0;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && token_q.size() != 0)) begin
          drv_valid <= 1'b1;
          drv_data  <= byte_q[0].data;
          drv_last  <= byte_q[0].last;
          gap_left  <= byte_q[0].gap_after;
          void'(byte_q.pop_front());
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lzc_token_t  want;
    int unsigned g;
    bit          took;
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      rcv_stall <= 0;
    end else begin
      took = out_if.valid && rcv_ready;
      if (took) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual dist %0d len %0d next %0d",
                   $realtime, out_if.distance, out_if.match_len, out_if.next_char);
          mismatch_count++;
        end else begin
          want = token_q.pop_front();
          check_field("distance", want.distance, out_if.distance);
          check_field("match_len", want.match_len, out_if.match_len);
          check_field("next_char", want.next_char, out_if.next_char);
          check_field("has_next_char", want.has_next_char, out_if.has_next_char);
          check_field("final_token", want.final_token, out_if.final_token);
        end
      end
      if (hold_left != 0) begin
        rcv_ready <= 1'b0;
      end else if (rcv_stall != 0) begin
        rcv_ready <= 1'b0;
        rcv_stall <= rcv_stall - 1;
      end else if (took && ((tokens_seen / 150) % 3) != 2) begin
        g = pick_gap();
        rcv_ready <= (g == 0);
        rcv_stall <= (g == 0) ? 0 : g - 1;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    byte_seq_t   seq;
    logic [7:0]  alpha[4];
    logic [7:0]  phrase[$];
    int unsigned n;
    int unsigned kind;
    int unsigned plen;

    seq = '{8'h00};
    queue_stream(seq, 1'b1, 1'b0);
    seq = '{8'hFF, 8'hFF, 8'hFF};
    queue_stream(seq, 1'b0, 1'b1);
    seq = '{8'h5A, 8'h5A};
    queue_stream(seq, 1'b0, 1'b0);
    seq = '{8'h11, 8'h22, 8'h11, 8'h22, 8'h33, 8'h11, 8'h22, 8'h44};
    queue_stream(seq, 1'b1, 1'b0);
    seq = '{8'h80, 8'h7F};
    queue_stream(seq, 1'b0, 1'b0);

    seq.delete();
    repeat (300) seq = {seq, 8'hC3};
    seq = {seq, 8'h3C};
    queue_stream(seq, 1'b0, 1'b1);

    seq.delete();
    repeat (257) seq = {seq, 8'h96};
    queue_stream(seq, 1'b1, 1'b0);

    seq.delete();
    repeat (LZC_WINDOW) seq = {seq, 8'($urandom_range(0, 255))};
    for (int i = 0; i < 30; i++) seq = {seq, seq[i]};
    queue_stream(seq, 1'b0, 1'b0);

    seq.delete();
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    repeat (320) seq = {seq, alpha[$urandom_range(0, 2)]};
    queue_stream(seq, 1'b0, 1'b0);

    while (byte_q.size() < RANDOM_ITEMS) begin
      seq.delete();
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
        plen = $urandom_range(1, 3);
        n    = $urandom_range(1, 80);
        repeat (n) seq = {seq, alpha[$urandom_range(0, plen)]};
      end else if (kind < 8) begin
        phrase.delete();
        plen = $urandom_range(3, 12);
        repeat (plen) phrase = {phrase, 8'($urandom_range(0, 255))};
        n = $urandom_range(20, 120);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 15) == 0) seq = {seq, 8'($urandom_range(0, 255))};
          else seq = {seq, phrase[i % plen]};
        end
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) seq = {seq, 8'($urandom_range(0, 255))};
      end
      queue_stream(seq, $urandom_range(0, 4) == 0, $urandom_range(0, 5) == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || drv_valid) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && token_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
